>>> sv/sofdt_pkg.sv
package sofdt_pkg;

	localparam int NumRounds = 80;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
	} state_t;

	// rolling schedule: entry 0 is the word of the current round
	typedef logic [15:0][31:0] window_t;

	localparam word_t H0 = 32'h67452301;
	localparam word_t H1 = 32'hEFCDAB89;
	localparam word_t H2 = 32'h98BADCFE;
	localparam word_t H3 = 32'h10325476;
	localparam word_t H4 = 32'hC3D2E1F0;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam word_t PadWord = 32'h80000000;
	localparam word_t LenWord = 32'd128;
	localparam logic [3:0] AsciiHigh = 4'h3;

	localparam state_t InitState = '{a: H0, b: H1, c: H2, d: H3, e: H4};

	function automatic word_t rotl1(input word_t x);
		return {x[30:0], x[31]};
	endfunction

	function automatic word_t rotl5(input word_t x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic word_t rotl30(input word_t x);
		return {x[1:0], x[31:2]};
	endfunction

	// four digit nibbles, lowest first, packed as big-endian ascii bytes
	function automatic word_t digits_to_word(input logic [15:0] nib);
		return {AsciiHigh, nib[3:0], AsciiHigh, nib[7:4],
			AsciiHigh, nib[11:8], AsciiHigh, nib[15:12]};
	endfunction

	function automatic state_t round_step(input state_t s, input word_t w, input int t);
		word_t f;
		word_t k;
		state_t r;
		if (t < 20) begin
			f = s.d ^ (s.b & (s.c ^ s.d));
			k = K0;
		end else if (t < 40) begin
			f = s.b ^ s.c ^ s.d;
			k = K1;
		end else if (t < 60) begin
			f = (s.b & s.c) | (s.d & (s.b | s.c));
			k = K2;
		end else begin
			f = s.b ^ s.c ^ s.d;
			k = K3;
		end
		r.a = rotl5(s.a) + f + s.e + k + w;
		r.b = s.a;
		r.c = rotl30(s.b);
		r.d = s.c;
		r.e = s.d;
		return r;
	endfunction

endpackage

>>> sv/sofdt_msg.sv
module sofdt_msg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  valid_i,
	input  logic [31:0]           high_digits,
	input  logic [31:0]           low_digits,
	output logic                  valid_o,
	output sofdt_pkg::window_t    win_o
);

	logic               valid_s0;
	sofdt_pkg::window_t win_s0;
	sofdt_pkg::window_t win_d;

	always_comb begin
		win_d     = '0;
		win_d[0]  = sofdt_pkg::digits_to_word(low_digits[15:0]);
		win_d[1]  = sofdt_pkg::digits_to_word(low_digits[31:16]);
		win_d[2]  = sofdt_pkg::digits_to_word(high_digits[15:0]);
		win_d[3]  = sofdt_pkg::digits_to_word(high_digits[31:16]);
		win_d[4]  = sofdt_pkg::PadWord;
		win_d[15] = sofdt_pkg::LenWord;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (adv) begin
			valid_s0 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			win_s0 <= win_d;
		end
	end

	assign valid_o = valid_s0;
	assign win_o   = win_s0;

endmodule

>>> sv/sofdt_round.sv
module sofdt_round #(
	parameter int ROUND = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  valid_i,
	input  sofdt_pkg::state_t     state_i,
	input  sofdt_pkg::window_t    win_i,
	output logic                  valid_o,
	output sofdt_pkg::state_t     state_o,
	output sofdt_pkg::window_t    win_o
);

	logic               valid_s1;
	sofdt_pkg::state_t  state_s1;
	sofdt_pkg::window_t win_s1;
	sofdt_pkg::window_t win_d;

	// shift the window down and append the next schedule word
	always_comb begin
		win_d[14:0] = win_i[15:1];
		win_d[15]   = sofdt_pkg::rotl1(win_i[13] ^ win_i[8] ^ win_i[2] ^ win_i[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			state_s1 <= sofdt_pkg::round_step(state_i, win_i[0], ROUND);
			win_s1   <= win_d;
		end
	end

	assign valid_o = valid_s1;
	assign state_o = state_s1;
	assign win_o   = win_s1;

endmodule

>>> sv/sha1_of_sixteen_digit_text_unit.sv
// channel | valid    | stall     | payload
// input   | in_valid | in_stall  | high_digits, low_digits
// output  | out_valid| out_stall | digest_word0 .. digest_word4
//
// one word enters per cycle while in_stall is low; 82 register stages lie between an
// accepted input word and its digest: one stage builds the padded
// block, one per sha-1 round (80 rounds unrolled), one for the final chaining add.
// reset clears only the valid bits of the stages; data registers are not reset.
// a held result in the output register freezes the whole pipeline, and
// in_stall follows out_stall in that cycle; nothing is dropped or repeated.
module sha1_of_sixteen_digit_text_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] high_digits,
	input  logic [31:0] low_digits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word0,
	output logic [31:0] digest_word1,
	output logic [31:0] digest_word2,
	output logic [31:0] digest_word3,
	output logic [31:0] digest_word4
);

	logic                adv;
	logic                valid_r [0:sofdt_pkg::NumRounds];
	sofdt_pkg::state_t   state_r [0:sofdt_pkg::NumRounds];
	sofdt_pkg::window_t  win_r   [0:sofdt_pkg::NumRounds-1];
	logic                valid_s82;
	sofdt_pkg::state_t   digest_s82;

	assign in_stall = valid_s82 && out_stall;
	assign adv      = !in_stall;

	sofdt_msg u_msg (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.valid_i    (in_valid),
		.high_digits(high_digits),
		.low_digits (low_digits),
		.valid_o    (valid_r[0]),
		.win_o      (win_r[0])
	);

	assign state_r[0] = sofdt_pkg::InitState;

	for (genvar i = 0; i < sofdt_pkg::NumRounds; i++) begin : g_round
		if (i < sofdt_pkg::NumRounds - 1) begin : g_mid
			sofdt_round #(.ROUND(i)) u_round (
				.clk    (clk),
				.arst_n (arst_n),
				.adv    (adv),
				.valid_i(valid_r[i]),
				.state_i(state_r[i]),
				.win_i  (win_r[i]),
				.valid_o(valid_r[i+1]),
				.state_o(state_r[i+1]),
				.win_o  (win_r[i+1])
			);
		end else begin : g_last
			sofdt_round #(.ROUND(i)) u_round (
				.clk    (clk),
				.arst_n (arst_n),
				.adv    (adv),
				.valid_i(valid_r[i]),
				.state_i(state_r[i]),
				.win_i  (win_r[i]),
				.valid_o(valid_r[i+1]),
				.state_o(state_r[i+1]),
				.win_o  ()
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s82 <= 1'b0;
		end else if (adv) begin
			valid_s82 <= valid_r[sofdt_pkg::NumRounds];
		end
	end

	// chaining add with the initial hash value
	always_ff @(posedge clk) begin
		if (adv) begin
			digest_s82.a <= state_r[sofdt_pkg::NumRounds].a + sofdt_pkg::H0;
			digest_s82.b <= state_r[sofdt_pkg::NumRounds].b + sofdt_pkg::H1;
			digest_s82.c <= state_r[sofdt_pkg::NumRounds].c + sofdt_pkg::H2;
			digest_s82.d <= state_r[sofdt_pkg::NumRounds].d + sofdt_pkg::H3;
			digest_s82.e <= state_r[sofdt_pkg::NumRounds].e + sofdt_pkg::H4;
		end
	end

	assign out_valid    = valid_s82;
	assign digest_word0 = digest_s82.a;
	assign digest_word1 = digest_s82.b;
	assign digest_word2 = digest_s82.c;
	assign digest_word3 = digest_s82.d;
	assign digest_word4 = digest_s82.e;

endmodule

>>> sv/sofdt_checker.sv
module sofdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word0,
	input logic [31:0] digest_word1,
	input logic [31:0] digest_word2,
	input logic [31:0] digest_word3,
	input logic [31:0] digest_word4
);

	// a held word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digest_word0) &&
			$stable(digest_word1) && $stable(digest_word2) &&
			$stable(digest_word3) && $stable(digest_word4))
		else $error("stalled digest changed");

	// input back-pressure comes only from a held output word
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall without held output");

	// a frozen pipeline cannot produce a new word
	a_rise_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_stall))
		else $error("output appeared while pipeline frozen");

	// pipeline comes out of reset empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind sha1_of_sixteen_digit_text_unit sofdt_checker u_sofdt_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	// one digest as five words, entry 0 is digest_word0
	typedef logic [4:0][31:0] digest_t;

	localparam int HoldCycles = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] high_digits;
	logic [31:0] low_digits;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;
	logic [31:0] digest_word4;

	digest_t pending_digests[$];
	int      mismatch_count = 0;
	bit      steady_flow = 1'b0;
	bit      hold_request = 1'b0;

	sha1_of_sixteen_digit_text_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.high_digits(high_digits),
		.low_digits(low_digits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digest_word0(digest_word0),
		.digest_word1(digest_word1),
		.digest_word2(digest_word2),
		.digest_word3(digest_word3),
		.digest_word4(digest_word4)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	// digest of the sixteen-character text: low word's nibbles first, then high word's
	function automatic digest_t sha1_of_digits(input sofdt_pkg::word_t hi,
		input sofdt_pkg::word_t lo);
		sofdt_pkg::word_t sched [16];
		logic [63:0]      digits;
		sofdt_pkg::word_t a, b, c, d, e, f, k, tmp, x;
		digest_t          h;
		int               i, j, s, t;
		digits = {hi, lo};
		for (i = 0; i < 4; i++) begin
			sched[i] = '0;
			for (j = 0; j < 4; j++)
				sched[i] = (sched[i] << 8) | (32'h30 + digits[(i * 4 + j) * 4 +: 4]);
		end
		sched[4] = 32'h80000000;
		for (i = 5; i < 15; i++)
			sched[i] = '0;
		sched[15] = 32'd128;
		a = sofdt_pkg::H0;
		b = sofdt_pkg::H1;
		c = sofdt_pkg::H2;
		d = sofdt_pkg::H3;
		e = sofdt_pkg::H4;
		for (t = 0; t < 80; t++) begin
			s = t % 16;
			if (t >= 16) begin
				x = sched[(s + 13) % 16] ^ sched[(s + 8) % 16] ^ sched[(s + 2) % 16] ^ sched[s];
				sched[s] = (x << 1) | (x >> 31);
			end
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = sofdt_pkg::K0;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = sofdt_pkg::K1;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sofdt_pkg::K2;
			end else begin
				f = b ^ c ^ d;
				k = sofdt_pkg::K3;
			end
			tmp = ((a << 5) | (a >> 27)) + f + e + k + sched[s];
			e = d;
			d = c;
			c = (b << 30) | (b >> 2);
			b = a;
			a = tmp;
		end
		h[0] = a + sofdt_pkg::H0;
		h[1] = b + sofdt_pkg::H1;
		h[2] = c + sofdt_pkg::H2;
		h[3] = d + sofdt_pkg::H3;
		h[4] = e + sofdt_pkg::H4;
		return h;
	endfunction

	// mostly short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// eight nibbles, each a decimal digit unless picked as wild (then any value)
	function automatic sofdt_pkg::word_t random_digits(input int wild_pct);
		sofdt_pkg::word_t w;
		int               n;
		w = '0;
		for (n = 0; n < 8; n++)
			if ($urandom_range(0, 99) < wild_pct)
				w[n * 4 +: 4] = 4'($urandom_range(0, 15));
			else
				w[n * 4 +: 4] = 4'($urandom_range(0, 9));
		return w;
	endfunction

	task automatic send_digits(input sofdt_pkg::word_t hi, input sofdt_pkg::word_t lo);
		int gap;
		gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		high_digits <= hi;
		low_digits <= lo;
		do @(posedge clk); while (in_stall);
		pending_digests.push_back(sha1_of_digits(hi, lo));
	endtask

	// receiver side: random holds, or one long hold when asked
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else if (!steady_flow && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat (idle_len() - 1) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		digest_t got;
		digest_t want;
		int      i;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = {digest_word4, digest_word3, digest_word2, digest_word1, digest_word0};
				if (pending_digests.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("digest with no word sent for it: %h", got);
				end else begin
					want = pending_digests.pop_front();
					for (i = 0; i < 5; i++)
						if (got[i] !== want[i]) begin
							mismatch_count++;
							if (mismatch_count <= 10)
								$display("digest_word%0d: expected %h, got %h",
									i, want[i], got[i]);
						end
				end
			end
		end
	end

	// every nibble value in every position, including the ones above nine
	task automatic test_digit_patterns();
		logic [3:0] nib;
		int         n;
		for (n = 0; n < 16; n++) begin
			nib = n[3:0];
			send_digits({8{nib}}, {8{nib}});
		end
		send_digits(32'hFEDCBA98, 32'h76543210);
		send_digits(32'h01234567, 32'h89ABCDEF);
		send_digits(32'hAAAAAAAA, 32'h55555555);
		send_digits(32'h00000000, 32'hFFFFFFFF);
		send_digits(32'hFFFFFFFF, 32'h00000000);
		send_digits(32'h99999999, 32'h00000001);
	endtask

	task automatic test_bcd_numbers();
		int n;
		for (n = 0; n < 600; n++)
			if (n % 5 == 4)
				send_digits(random_digits(30), random_digits(30));
			else
				send_digits(random_digits(0), random_digits(0));
	endtask

	task automatic test_raw_words();
		int n;
		steady_flow = 1'b1;
		for (n = 0; n < 150; n++) begin
			if (n == 80)
				steady_flow = 1'b0;
			send_digits($urandom, $urandom);
		end
	endtask

	// long output hold while words keep coming, so the pipe fills and stalls its input
	task automatic test_output_hold();
		int n;
		hold_request = 1'b1;
		steady_flow = 1'b1;
		for (n = 0; n < 200; n++)
			send_digits(random_digits(10), random_digits(10));
		steady_flow = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		high_digits = '0;
		low_digits = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_digit_patterns();
		test_bcd_numbers();
		test_raw_words();
		test_output_hold();
		in_valid <= 1'b0;
		while (pending_digests.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sha1_of_sixteen_digit_text_unit.f
sv/sofdt_pkg.sv
sv/sofdt_msg.sv
sv/sofdt_round.sv
sv/sha1_of_sixteen_digit_text_unit.sv
sv/sofdt_checker.sv
tb/sv/testbench.sv
